### rtl/core/fbs_pkg.sv
// ----------------------------------------------------------------------------
// fbs_pkg
// Shared types and constants for the single-precision binary scale pipeline.
// ----------------------------------------------------------------------------
package fbs_pkg;

    localparam int unsigned ExpW  = 8;
    localparam int unsigned FracW = 23;
    localparam int unsigned ScaleW = 16;
    localparam int unsigned WordW = 32;
    localparam int unsigned InDataW = 48;
    localparam int unsigned OutDataW = 40;
    localparam int unsigned SumW = 18;
    localparam int unsigned LzW = 5;

    // operand class decoded in the first stage
    typedef enum logic [1:0] {
        CLS_PASS = 2'd0,
        CLS_NORM = 2'd1,
        CLS_SUBN = 2'd2
    } cls_t;

    // stage 1 to stage 2 payload
    typedef struct packed {
        logic                     sign;
        cls_t                     cls;
        logic [FracW-1:0]         frac;
        logic [WordW-1:0]         raw;
        logic signed [SumW-1:0]   ne;     // e + n for normals
        logic signed [ScaleW-1:0] n;
        logic [LzW-1:0]           lz;
    } s1_t;

    // stage 2 to stage 3 payload: decision and shift amounts
    typedef struct packed {
        logic               sign;
        logic               pass;
        logic               inf;
        logic               uf;
        logic               right;        // right shift of mant
        logic               zero;
        logic [4:0]         shamt;
        logic [ExpW-1:0]    exp_out;
        logic [FracW:0]     mant;         // with hidden one when needed
        logic [WordW-1:0]   raw;
    } s2_t;

    // leading zero count of a 23-bit fraction, 23 when zero
    function automatic logic [LzW-1:0] lzc23(input logic [FracW-1:0] f);
        logic [LzW-1:0] z;
        logic           hit;
        z   = LzW'(FracW);
        hit = 1'b0;
        for (int i = FracW - 1; i >= 0; i--) begin
            if (!hit && f[i]) begin
                z   = LzW'(FracW - 1 - i);
                hit = 1'b1;
            end
        end
        return z;
    endfunction

endpackage

### rtl/core/fbs_stage_pipe.sv
// ----------------------------------------------------------------------------
// fbs_stage_pipe
// One pipeline register with valid and backpressure; holds under stall.
// ----------------------------------------------------------------------------
module fbs_stage_pipe #(
    parameter int unsigned W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    logic         valid_reg;
    logic [W-1:0] data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // valid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end
endmodule

### rtl/core/fp32_binary_scale.sv
// ----------------------------------------------------------------------------
// fp32_binary_scale
// Multiplies an IEEE single value by 2^n through exponent arithmetic.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                          tuser
// s_axis   in   value_bits[31:0], scale_exp[47:32]           -
// m_axis   out  result_bits[31:0], underflow[32], overflow[33] -
//
// three register stages: decode/lzc, decide, shift/assemble
// one request per cycle sustained while m_axis_tready stays high
// rst_n clears only the stage valid bits
// a stall at m_axis holds every full stage; an empty stage still fills
module fp32_binary_scale (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [fbs_pkg::InDataW-1:0]  s_axis_tdata,  // value_bits, scale_exp
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [fbs_pkg::OutDataW-1:0] m_axis_tdata   // result, uf, of, zero pad
);
    import fbs_pkg::*;

    logic [WordW-1:0]         v;
    logic signed [ScaleW-1:0] n_in;
    s1_t s1_next, s1_q;
    s2_t s2_next, s2_q;
    logic [OutDataW-1:0] s3_next;
    logic v1, r1, v2, r2;

    assign v    = s_axis_tdata[31:0];
    assign n_in = s_axis_tdata[47:32];

    // stage 1: classify and count leading zeros
    always_comb
    begin
        s1_next.sign = v[31];
        s1_next.frac = v[22:0];
        s1_next.raw  = v;
        s1_next.n    = n_in;
        s1_next.ne   = SumW'($signed({1'b0, v[30:23]})) + SumW'(n_in);
        s1_next.lz   = lzc23(v[22:0]);
        if (v[30:23] == 8'hFF || (v[30:23] == 8'h00 && v[22:0] == '0))
            s1_next.cls = CLS_PASS;
        else if (v[30:23] != 8'h00)
            s1_next.cls = CLS_NORM;
        else
            s1_next.cls = CLS_SUBN;
    end

    fbs_stage_pipe #(.W($bits(s1_t))) u_s1 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s1_next),
        .out_valid(v1), .out_ready(r1), .out_data(s1_q)
    );

    // stage 2: choose path and shift amounts
    logic signed [SumW-1:0] sh_n, ne_s;
    always_comb
    begin
        sh_n = 18'sd1 - s1_q.ne;
        ne_s = SumW'(s1_q.n) - SumW'($signed({1'b0, s1_q.lz}));
        s2_next = '0;
        s2_next.sign = s1_q.sign;
        s2_next.raw  = s1_q.raw;
        case (s1_q.cls)
            CLS_PASS: s2_next.pass = 1'b1;
            CLS_NORM:
            begin
                if (s1_q.ne <= 0)
                begin
                    s2_next.uf    = 1'b1;
                    s2_next.right = 1'b1;
                    s2_next.mant  = {1'b1, s1_q.frac};
                    if (sh_n >= 24) s2_next.zero = 1'b1;
                    else            s2_next.shamt = sh_n[4:0];
                end
                else if (s1_q.ne >= 255)
                    s2_next.inf = 1'b1;
                else
                begin
                    s2_next.exp_out = s1_q.ne[7:0];
                    s2_next.mant    = {1'b0, s1_q.frac};
                end
            end
            default:
            begin
                s2_next.mant = {1'b0, s1_q.frac};
                if (s1_q.n <= 0)
                begin
                    s2_next.right = 1'b1;
                    if (s1_q.n <= -16'sd23) s2_next.zero = 1'b1;
                    else                    s2_next.shamt = 5'(-s1_q.n);
                end
                else if ($signed({11'b0, s1_q.lz}) >= s1_q.n)
                    s2_next.shamt = 5'(s1_q.n);
                else if (ne_s >= 255)
                    s2_next.inf = 1'b1;
                else
                begin
                    // the leading one shifts out above the fraction field
                    s2_next.exp_out  = ne_s[7:0];
                    s2_next.shamt    = s1_q.lz + 5'd1;
                end
            end
        endcase
    end

    fbs_stage_pipe #(.W($bits(s2_t))) u_s2 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(v1), .in_ready(r1), .in_data(s2_next),
        .out_valid(v2), .out_ready(r2), .out_data(s2_q)
    );

    // stage 3: barrel shift and assemble
    logic [FracW:0] shifted;
    logic [FracW-1:0] frac_o;
    always_comb
    begin
        if (s2_q.right) shifted = s2_q.mant >> s2_q.shamt;
        else            shifted = s2_q.mant << s2_q.shamt;
        frac_o = s2_q.zero ? '0 : shifted[FracW-1:0];
        if (s2_q.pass)
            s3_next = {6'h00, 2'b00, s2_q.raw};
        else if (s2_q.inf)
            s3_next = {6'h00, 2'b10, s2_q.sign, 8'hFF, 23'h0};
        else
            s3_next = {6'h00, 1'b0, s2_q.uf, s2_q.sign, s2_q.exp_out, frac_o};
    end

    fbs_stage_pipe #(.W(OutDataW)) u_s3 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(v2), .in_ready(r2), .in_data(s3_next),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
    );

    // flags never both set
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[32] && m_axis_tdata[33]))
        else $error("both flags set");
    // overflow means infinity
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[33]) |-> m_axis_tdata[30:0] == 31'h7F800000)
        else $error("overflow without infinity");
    // underflow gives zero exponent
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[32]) |-> m_axis_tdata[30:23] == 8'h00)
        else $error("underflow with nonzero exponent");
endmodule

### bench/fbs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fbs_checker
// Watches both stream channels of the binary scale block, computes the
// scaled value and flags for each accepted request, and compares in order.
// ----------------------------------------------------------------------------
module fbs_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // value_bits, scale_exp
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // result_bits, underflow, overflow, pad
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [31:0] bits;
        logic        uf;
        logic        of;
    } scaled_t;

    scaled_t scaled_q[$];

    // leading zeros of a 23-bit fraction
    function automatic int frac_lz(input logic [22:0] f);
        int z;
        z = 0;
        for (int i = 22; i >= 0; i--)
        begin
            if (f[i])
                break;
            z++;
        end
        return z;
    endfunction

    // exponent arithmetic scaling by 2^n
    function automatic scaled_t scale_value(input logic [31:0] v, input logic [15:0] raw_n);
        scaled_t     r;
        int          n;
        int          e;
        int          ne;
        int          sh;
        int          z;
        logic [23:0] full;
        logic [22:0] frac;
        n    = $signed(raw_n);
        e    = v[30:23];
        frac = v[22:0];
        r.bits = v;
        r.uf = 1'b0;
        r.of = 1'b0;
        if (e == 255 || (e == 0 && frac == 0))
            r.bits = v;
        else if (e != 0)
        begin
            ne = e + n;
            if (ne <= 0)
            begin
                sh = 1 - ne;
                full = {1'b1, frac};
                r.uf = 1'b1;
                full = (sh >= 24) ? 24'd0 : (full >> sh);
                r.bits = {v[31], 8'd0, full[22:0]};
            end
            else if (ne >= 255)
            begin
                r.of = 1'b1;
                r.bits = {v[31], 8'hff, 23'd0};
            end
            else
                r.bits = {v[31], ne[7:0], frac};
        end
        else if (n <= 0)
        begin
            sh = -n;
            r.bits = {v[31], 8'd0, (sh >= 23) ? 23'd0 : (frac >> sh)};
        end
        else
        begin
            z = frac_lz(frac);
            if (z >= n)
                r.bits = {v[31], 8'd0, frac << n};
            else
            begin
                ne = n - z;
                if (ne >= 255)
                begin
                    r.of = 1'b1;
                    r.bits = {v[31], 8'hff, 23'd0};
                end
                else
                    r.bits = {v[31], ne[7:0], 23'(frac << (z + 1))};
            end
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [39:0] got, input scaled_t want);
        $display("mismatch %s: got %h want bits %h uf %b of %b", what, got,
                 want.bits, want.uf, want.of);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // predict on request, compare on result
    always @(posedge clk)
    begin
        scaled_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                scaled_q.push_back(scale_value(s_axis_tdata[31:0], s_axis_tdata[47:32]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (scaled_q.size() == 0)
                    report("unexpected", m_axis_tdata, '0);
                else
                begin
                    want = scaled_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.bits)
                        report("result_bits", m_axis_tdata, want);
                    if (m_axis_tdata[32] !== want.uf)
                        report("underflow", m_axis_tdata, want);
                    if (m_axis_tdata[33] !== want.of)
                        report("overflow", m_axis_tdata, want);
                end
            end
        end
        pending = scaled_q.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random requests into the binary scale block with
// random gaps and output stalls; a checker module compares every result.
// ----------------------------------------------------------------------------
module tb;

    localparam int RandCount = 1700;
    localparam int IdleLimit = 2000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // value_bits, scale_exp
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // result_bits, underflow, overflow, pad
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          out_wait;

    fp32_binary_scale dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    fbs_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // one request, then a random gap
    task automatic send(input logic [31:0] v, input logic [15:0] n);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {n, v};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // random operand biased toward the interesting classes
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: v[30:23] = 8'd0;
            1: v[30:23] = 8'hff;
            2: v[30:0] = {8'd0, 23'(1) << $urandom_range(0, 22)};
            3: v[30:23] = $urandom_range(0, 1) ? 8'd1 : 8'hfe;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_scale();
        int k;
        k = $urandom_range(0, 5);
        if (k == 0)
            return 16'($urandom);
        else if (k == 1)
            return 16'($signed($urandom_range(0, 560)) - 280);
        return 16'($signed($urandom_range(0, 60)) - 30);
    endfunction

    // receiver stalls: a fresh random wait after each result
    always @(posedge clk)
    begin
        int w;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            out_wait      <= 0;
        end
        else if (out_wait > 0)
        begin
            out_wait      <= out_wait - 1;
            m_axis_tready <= (out_wait == 1);
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
            out_wait      <= w;
            m_axis_tready <= (w == 0);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        idle_cycles   = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // zeros, infinities, nan
        send(32'h0000_0000, 16'h0005);
        send(32'h8000_0000, 16'h8000);
        send(32'h7f80_0000, 16'h7fff);
        send(32'hff80_0000, 16'h8000);
        send(32'h7fc0_0001, 16'h0003);
        // normals: plain, overflow to exactly 255, underflow, flush
        send(32'h3f80_0000, 16'h0001);
        send(32'h3f80_0000, 16'd128);
        send(32'hbf80_0000, 16'h7fff);
        send(32'h3fff_ffff, -16'sd127);
        send(32'h3fff_ffff, -16'sd149);
        send(32'hbf80_0000, -16'sd150);
        send(32'h0080_0000, 16'h8000);
        send(32'h7f7f_ffff, 16'h0001);
        send(32'hffff_ffff, 16'hffff);
        // subnormals: right, flush, left staying, normalize, overflow
        send(32'h007f_ffff, -16'sd3);
        send(32'h8000_0001, -16'sd23);
        send(32'h0000_0001, 16'd22);
        send(32'h0000_0001, 16'd23);
        send(32'h0040_0000, 16'd1);
        send(32'h007f_ffff, 16'd254);
        send(32'h807f_ffff, 16'd255);
        send(32'h0000_0001, 16'd277);
        send(32'h0000_0001, 16'd276);
        send(32'h0000_0001, 16'h7fff);
        // pause until the pipeline drains
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        for (int i = 0; i < RandCount; i++)
            send(pick_value(), pick_scale());
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

### fp32_binary_scale.f
rtl/core/fbs_pkg.sv
rtl/core/fbs_stage_pipe.sv
rtl/core/fp32_binary_scale.sv
bench/fbs_checker.sv
bench/tb.sv
